// File: hw/rtl/kidmap_pkg.sv
`timescale 1ns / 1ps

package kidmap_pkg;

    // Operation codes carried on the kind port.
    localparam logic [2:0] KIND_ADD      = 3'd0;
    localparam logic [2:0] KIND_DELETE   = 3'd1;
    localparam logic [2:0] KIND_FIND_KEY = 3'd2;
    localparam logic [2:0] KIND_FIND_ID  = 3'd3;
    localparam logic [2:0] KIND_CLEAR    = 3'd4;

    // Status codes returned with each result word.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_PRESENT   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    // Identifier returned when there is none to give.
    localparam logic [31:0] NO_ID = 32'hFFFF_FFFF;

    // One table entry as it is held in the entry memory.
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] key_high;
        logic [63:0] key_low;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hw/rtl/kidmap_ram.sv
`timescale 1ns / 1ps

module kidmap_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 32
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with the data registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/key_to_id_map_table.sv
`timescale 1ns / 1ps

// Table of up to ENTRIES 128-bit keys, each mapped to a 32-bit serial ID. A command word is
// taken when start is high and busy is low; its result word appears on status, found_id,
// found_key_high and found_key_low for exactly one cycle while done is high, and the receiver
// cannot hold it off. Clear and unused kinds answer in the cycle after they are taken. Add,
// delete and both finds scan the entry memory one entry per cycle through its single
// registered read port, up to the entry count; a delete hit then reads the last entry and
// writes it into the freed slot. A new command may be started in the cycle that done is high.

module key_to_id_map_table
    import kidmap_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [63:0] key_high,
    input  logic [63:0] key_low,
    input  logic [31:0] query_id,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] found_id,
    output logic [63:0] found_key_high,
    output logic [63:0] found_key_low
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR
    } state_t;

    state_t            state_reg;
    logic [2:0]        kind_reg;
    logic [63:0]       key_high_reg;
    logic [63:0]       key_low_reg;
    logic [31:0]       qid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       serial_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              cmp_valid_reg;
    logic [ADDR_W-1:0] cmp_idx_reg;
    logic [ADDR_W-1:0] hit_idx_reg;
    logic [31:0]       hit_id_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [31:0]       found_id_reg;
    logic [63:0]       fkh_reg;
    logic [63:0]       fkl_reg;

    entry_t            rd_entry;
    entry_t            wr_entry;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CNT_W-1:0]  last_cnt;
    logic              entry_match;
    logic              scan_miss;
    logic              has_room;

    kidmap_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    // Comparison of the word just read against the command being served.
    always_comb
    begin
        last_cnt  = CNT_W'(count_reg - CNT_W'(1));
        has_room  = (count_reg < CNT_W'(ENTRIES));
        scan_miss = !cmp_valid_reg && (scan_idx_reg == count_reg);
        if (kind_reg == KIND_FIND_KEY)
        begin
            entry_match = cmp_valid_reg && (rd_entry.id == qid_reg);
        end
        else
        begin
            entry_match = cmp_valid_reg && (rd_entry.key_high == key_high_reg)
                          && (rd_entry.key_low == key_low_reg);
        end
    end

    // Memory port control: scan reads, the append write and the moved last entry.
    always_comb
    begin
        ram_raddr = scan_idx_reg[ADDR_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        wr_entry  = '{id: serial_reg, key_high: key_high_reg, key_low: key_low_reg};
        case (state_reg)
            ST_SCAN:
            begin
                ram_we = scan_miss && (kind_reg == KIND_ADD) && has_room;
            end
            ST_MOVE_RD:
            begin
                ram_raddr = last_cnt[ADDR_W-1:0];
            end
            ST_MOVE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx_reg;
                wr_entry  = rd_entry;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer with the result word registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            serial_reg    <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg      <= kind;
                        key_high_reg  <= key_high;
                        key_low_reg   <= key_low;
                        qid_reg       <= query_id;
                        scan_idx_reg  <= '0;
                        cmp_valid_reg <= 1'b0;
                        fkh_reg       <= '0;
                        fkl_reg       <= '0;
                        found_id_reg  <= NO_ID;
                        if (kind inside {KIND_ADD, KIND_DELETE, KIND_FIND_KEY, KIND_FIND_ID})
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else if (kind == KIND_CLEAR)
                        begin
                            count_reg  <= '0;
                            status_reg <= STATUS_OK;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            status_reg <= STATUS_NOT_FOUND;
                            done_reg   <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (entry_match)
                    begin
                        cmp_valid_reg <= 1'b0;
                        hit_idx_reg   <= cmp_idx_reg;
                        hit_id_reg    <= rd_entry.id;
                        case (kind_reg)
                            KIND_ADD:
                            begin
                                status_reg   <= STATUS_PRESENT;
                                found_id_reg <= rd_entry.id;
                                done_reg     <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end
                            KIND_DELETE:
                            begin
                                state_reg <= ST_MOVE_RD;
                            end
                            KIND_FIND_KEY:
                            begin
                                status_reg   <= STATUS_OK;
                                found_id_reg <= qid_reg;
                                fkh_reg      <= rd_entry.key_high;
                                fkl_reg      <= rd_entry.key_low;
                                done_reg     <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end
                            default:
                            begin
                                status_reg   <= STATUS_OK;
                                found_id_reg <= rd_entry.id;
                                done_reg     <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end
                        endcase
                    end
                    else if (scan_miss)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                        if (kind_reg == KIND_ADD)
                        begin
                            if (has_room)
                            begin
                                status_reg   <= STATUS_OK;
                                found_id_reg <= serial_reg;
                                serial_reg   <= serial_reg + 32'd1;
                                count_reg    <= CNT_W'(count_reg + CNT_W'(1));
                            end
                            else
                            begin
                                status_reg <= STATUS_FULL;
                            end
                        end
                        else
                        begin
                            status_reg <= STATUS_NOT_FOUND;
                        end
                    end
                    else if (scan_idx_reg != count_reg)
                    begin
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= scan_idx_reg[ADDR_W-1:0];
                        scan_idx_reg  <= CNT_W'(scan_idx_reg + CNT_W'(1));
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                    end
                end
                ST_MOVE_RD:
                begin
                    state_reg <= ST_MOVE_WR;
                end
                ST_MOVE_WR:
                begin
                    count_reg    <= last_cnt;
                    status_reg   <= STATUS_OK;
                    found_id_reg <= hit_id_reg;
                    done_reg     <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_id       = found_id_reg;
    assign found_key_high = fkh_reg;
    assign found_key_low  = fkl_reg;

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    // The memory is written only while a command is in progress.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("entry memory written while idle");

    // A pending comparison exists only during the scan.
    a_cmp_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == ST_SCAN))
        else $error("comparison pending outside scan");

    // A successful append hands out the serial and advances the counter by one.
    a_serial_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (kind_reg == KIND_ADD) && (status_reg == STATUS_OK))
        |-> (serial_reg == found_id_reg + 32'd1))
        else $error("serial counter out of step with assigned ID");

    // Removing an entry shrinks the table by exactly one.
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE_WR) |=> (count_reg == CNT_W'($past(count_reg) - CNT_W'(1))))
        else $error("delete did not shrink the table by one");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb
    import kidmap_pkg::*;
;

    localparam int ENTRIES = 32;

    // The stimulus plan and the checker each keep their own copy of the table.
    localparam int unsigned VIEW_PLAN  = 0;
    localparam int unsigned VIEW_CHECK = 1;

    // Kind values with no operation behind them; the block answers them with not found.
    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd6;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;

    localparam int unsigned ITEM_TARGET = 1650;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 10;

    // Workload modes of the random part.
    localparam int unsigned MODE_FILL  = 0;
    localparam int unsigned MODE_DRAIN = 1;
    localparam int unsigned MODE_MIXED = 2;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] khi;
        logic [63:0] klo;
        logic [31:0] qid;
    } map_word_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] id;
        logic [63:0] khi;
        logic [63:0] klo;
    } map_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  kind = KIND_CLEAR;
    logic [63:0] key_high = '0;
    logic [63:0] key_low = '0;
    logic [31:0] query_id = '0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] found_id;
    logic [63:0] found_key_high;
    logic [63:0] found_key_low;

    // Table copies, one per view.
    logic [63:0] tbl_key_high [2][ENTRIES];
    logic [63:0] tbl_key_low  [2][ENTRIES];
    logic [31:0] tbl_id       [2][ENTRIES];
    int unsigned tbl_count    [2];
    logic [31:0] tbl_serial   [2];

    map_word_t   pending_words [$];
    map_reply_t  expected_replies [$];
    map_word_t   word_now;
    map_reply_t  reply_now;
    map_reply_t  reply_want;

    int unsigned total_words;
    int unsigned plain_words;
    int unsigned words_taken;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned gap_left;
    int unsigned steady_left;
    int unsigned gap_draw;
    int unsigned gap_len;
    int unsigned kind_taken [8];
    int unsigned status_seen [4];

    key_to_id_map_table #(
        .ENTRIES        (ENTRIES)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .key_high       (key_high),
        .key_low        (key_low),
        .query_id       (query_id),
        .done           (done),
        .status         (status),
        .found_id       (found_id),
        .found_key_high (found_key_high),
        .found_key_low  (found_key_low)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Slot holding the given key, or ENTRIES when it is absent.
    function automatic int unsigned slot_by_key(input int unsigned side,
                                                input logic [63:0] khi,
                                                input logic [63:0] klo);
        int unsigned i;
        for (i = 0; i < tbl_count[side]; i++)
        begin
            if (tbl_key_high[side][i] == khi && tbl_key_low[side][i] == klo)
                return i;
        end
        return ENTRIES;
    endfunction

    // Lowest slot holding the given ID, or ENTRIES when it is absent.
    function automatic int unsigned slot_by_id(input int unsigned side, input logic [31:0] id);
        int unsigned i;
        for (i = 0; i < tbl_count[side]; i++)
        begin
            if (tbl_id[side][i] == id)
                return i;
        end
        return ENTRIES;
    endfunction

    // Applies one command word to a table copy and returns the result word it gives.
    function automatic map_reply_t apply_to_table(input int unsigned side, input map_word_t w);
        map_reply_t  r;
        int unsigned slot;
        int unsigned last;
        r.st  = STATUS_NOT_FOUND;
        r.id  = NO_ID;
        r.khi = '0;
        r.klo = '0;
        slot  = slot_by_key(side, w.khi, w.klo);
        case (w.op)
            KIND_ADD:
            begin
                if (slot < ENTRIES)
                begin
                    r.st = STATUS_PRESENT;
                    r.id = tbl_id[side][slot];
                end
                else if (tbl_count[side] >= ENTRIES)
                begin
                    r.st = STATUS_FULL;
                end
                else
                begin
                    tbl_key_high[side][tbl_count[side]] = w.khi;
                    tbl_key_low[side][tbl_count[side]]  = w.klo;
                    tbl_id[side][tbl_count[side]]       = tbl_serial[side];
                    tbl_count[side]++;
                    r.st = STATUS_OK;
                    r.id = tbl_serial[side];
                    tbl_serial[side] = tbl_serial[side] + 32'd1;
                end
            end
            KIND_DELETE:
            begin
                // The last entry moves into the freed slot.
                if (slot < ENTRIES)
                begin
                    last = tbl_count[side] - 1;
                    r.st = STATUS_OK;
                    r.id = tbl_id[side][slot];
                    tbl_key_high[side][slot] = tbl_key_high[side][last];
                    tbl_key_low[side][slot]  = tbl_key_low[side][last];
                    tbl_id[side][slot]       = tbl_id[side][last];
                    tbl_count[side]          = last;
                end
            end
            KIND_FIND_KEY:
            begin
                slot = slot_by_id(side, w.qid);
                if (slot < ENTRIES)
                begin
                    r.st  = STATUS_OK;
                    r.id  = w.qid;
                    r.khi = tbl_key_high[side][slot];
                    r.klo = tbl_key_low[side][slot];
                end
            end
            KIND_FIND_ID:
            begin
                if (slot < ENTRIES)
                begin
                    r.st = STATUS_OK;
                    r.id = tbl_id[side][slot];
                end
            end
            KIND_CLEAR:
            begin
                tbl_count[side] = 0;
                r.st = STATUS_OK;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Queues one command word and advances the planning copy of the table.
    task automatic plan_word(input logic [2:0] op, input logic [63:0] khi,
                             input logic [63:0] klo, input logic [31:0] qid);
        map_word_t w;
        w.op  = op;
        w.khi = khi;
        w.klo = klo;
        w.qid = qid;
        void'(apply_to_table(VIEW_PLAN, w));
        pending_words.push_back(w);
        if (op <= KIND_CLEAR)
            plain_words++;
    endtask

    // Picks a key: a stored one with hit_pct percent chance, else one sharing a half with a
    // stored key, else a random or extreme one.
    task automatic pick_key(input int unsigned hit_pct, output logic [63:0] khi,
                            output logic [63:0] klo);
        int unsigned r;
        int unsigned slot;
        r    = $urandom_range(0, 99);
        khi  = {$urandom, $urandom};
        klo  = {$urandom, $urandom};
        slot = (tbl_count[VIEW_PLAN] != 0) ? $urandom_range(0, tbl_count[VIEW_PLAN] - 1) : 0;
        if (tbl_count[VIEW_PLAN] != 0 && r < hit_pct)
        begin
            khi = tbl_key_high[VIEW_PLAN][slot];
            klo = tbl_key_low[VIEW_PLAN][slot];
        end
        else if (tbl_count[VIEW_PLAN] != 0 && r < hit_pct + 15)
        begin
            if ($urandom_range(0, 1) != 0)
                khi = tbl_key_high[VIEW_PLAN][slot];
            else
                klo = tbl_key_low[VIEW_PLAN][slot];
        end
        else if (r >= 95)
        begin
            khi = {64{r[0]}};
            klo = {64{r[1]}};
        end
    endtask

    // Picks an ID to look up: mostly a stored one, sometimes one near the counter
    // or a random value.
    function automatic logic [31:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tbl_count[VIEW_PLAN] != 0 && r < 70)
            return tbl_id[VIEW_PLAN][$urandom_range(0, tbl_count[VIEW_PLAN] - 1)];
        else if (r < 85)
            return tbl_serial[VIEW_PLAN] - $urandom_range(0, 3);
        else
            return {$urandom};
    endfunction

    // Stimulus plan, then reset, then wait for the run to drain.
    initial
    begin
        int unsigned mode;
        int unsigned run_len;
        int unsigned add_w;
        int unsigned del_w;
        int unsigned r;
        int unsigned n;
        logic [63:0] khi;
        logic [63:0] klo;

        tbl_count[VIEW_PLAN]   = 0;
        tbl_count[VIEW_CHECK]  = 0;
        tbl_serial[VIEW_PLAN]  = '0;
        tbl_serial[VIEW_CHECK] = '0;

        // Directed opening: misses on an empty table, extreme keys, a present key,
        // keys matching in one half only, unused kinds, deletes that move the last
        // entry and the one that empties the table, and a clear that keeps the counter.
        plan_word(KIND_FIND_KEY, '0, '0, 32'd0);
        plan_word(KIND_FIND_ID, '0, '0, '0);
        plan_word(KIND_DELETE, '0, '0, '0);
        plan_word(KIND_ADD, '0, '0, '0);
        plan_word(KIND_ADD, '1, '1, '1);
        plan_word(KIND_ADD, '0, '0, '0);
        plan_word(KIND_ADD, '1, '0, '0);
        plan_word(KIND_FIND_ID, '0, '1, '0);
        plan_word(KIND_FIND_ID, '1, '1, '0);
        plan_word(KIND_FIND_KEY, '0, '0, 32'd1);
        plan_word(KIND_FIND_KEY, '1, '1, NO_ID);
        plan_word(KIND_SPARE_A, '1, '1, 32'd1);
        plan_word(KIND_SPARE_B, '0, '0, '1);
        plan_word(KIND_SPARE_C, '1, '1, '0);
        plan_word(KIND_DELETE, '0, '0, '0);
        plan_word(KIND_FIND_KEY, '0, '0, 32'd2);
        plan_word(KIND_DELETE, '1, '1, '0);
        plan_word(KIND_DELETE, '1, '0, '0);
        plan_word(KIND_FIND_KEY, '0, '0, 32'd2);
        khi = {$urandom, $urandom};
        klo = {$urandom, $urandom};
        plan_word(KIND_ADD, khi, klo, '0);
        plan_word(KIND_CLEAR, '1, '1, '1);
        plan_word(KIND_FIND_ID, khi, klo, '0);
        plan_word(KIND_ADD, '1, '1, '0);

        // Random part in runs that favour filling, draining or a mix of both.
        while (plain_words < ITEM_TARGET)
        begin
            mode    = $urandom_range(MODE_FILL, MODE_MIXED);
            run_len = $urandom_range(30, 90);
            add_w   = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 15 : 35;
            del_w   = (mode == MODE_FILL) ? 5 : (mode == MODE_DRAIN) ? 55 : 25;
            for (n = 0; n < run_len; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < add_w)
                begin
                    pick_key(30, khi, klo);
                    plan_word(KIND_ADD, khi, klo, {$urandom});
                end
                else if (r < add_w + del_w)
                begin
                    pick_key(75, khi, klo);
                    plan_word(KIND_DELETE, khi, klo, {$urandom});
                end
                else if (r < 94)
                begin
                    pick_key(60, khi, klo);
                    if (r[0])
                        plan_word(KIND_FIND_KEY, khi, klo, pick_id());
                    else
                        plan_word(KIND_FIND_ID, khi, klo, {$urandom});
                end
                else if (r < 96)
                begin
                    pick_key(50, khi, klo);
                    plan_word(KIND_CLEAR, khi, klo, {$urandom});
                end
                else
                begin
                    pick_key(50, khi, klo);
                    plan_word(KIND_SPARE_A + 3'($urandom_range(0, 2)), khi, klo, pick_id());
                end
            end
        end
        total_words = pending_words.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken != total_words || expected_replies.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Covered %0d command words: %0d add, %0d delete, %0d find key, %0d find id, %0d clear, %0d unused kind.",
                 words_taken, kind_taken[KIND_ADD], kind_taken[KIND_DELETE],
                 kind_taken[KIND_FIND_KEY], kind_taken[KIND_FIND_ID], kind_taken[KIND_CLEAR],
                 kind_taken[KIND_SPARE_A] + kind_taken[KIND_SPARE_B] + kind_taken[KIND_SPARE_C]);
        $display("Checked %0d result words: %0d ok, %0d present, %0d not found, %0d full; %0d mismatches.",
                 results_seen, status_seen[STATUS_OK], status_seen[STATUS_PRESENT],
                 status_seen[STATUS_NOT_FOUND], status_seen[STATUS_FULL], mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Puts a command word on the input ports.
    task automatic present_word(input map_word_t w);
        kind     <= w.op;
        key_high <= w.khi;
        key_low  <= w.klo;
        query_id <= w.qid;
    endtask

    // Driver: takes words from the plan, predicts each one as it is accepted and
    // leaves gaps of random length between words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            gap_left    <= 0;
            steady_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                reply_now = apply_to_table(VIEW_CHECK, word_now);
                expected_replies.push_back(reply_now);
                words_taken++;
                kind_taken[word_now.op]++;

                // Mostly short gaps, a few long ones, and now and then a steady burst.
                gap_draw = $urandom_range(0, 99);
                if (steady_left != 0)
                begin
                    steady_left <= steady_left - 1;
                    gap_len = 0;
                end
                else
                begin
                    if (gap_draw < 3)
                        steady_left <= $urandom_range(20, 60);
                    gap_len = (gap_draw < 60) ? 0 :
                              (gap_draw < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
                end

                if (gap_len == 0 && pending_words.size() != 0)
                begin
                    word_now = pending_words.pop_front();
                    present_word(word_now);
                end
                else
                begin
                    start    <= 1'b0;
                    gap_left <= gap_len;
                end
            end
            else if (!start)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    word_now = pending_words.pop_front();
                    present_word(word_now);
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor: every result word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: result word with nothing expected: status %0d id %h key %h_%h",
                             status, found_id, found_key_high, found_key_low);
            end
            else
            begin
                reply_want = expected_replies.pop_front();
                status_seen[reply_want.st]++;
                if (status !== reply_want.st || found_id !== reply_want.id ||
                    found_key_high !== reply_want.khi || found_key_low !== reply_want.klo)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: result word %0d: expected status %0d id %h key %h_%h",
                                 results_seen, reply_want.st, reply_want.id,
                                 reply_want.khi, reply_want.klo);
                        $display("       got status %0d id %h key %h_%h",
                                 status, found_id, found_key_high, found_key_low);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles.", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// File: sim.f
hw/rtl/kidmap_pkg.sv
hw/rtl/kidmap_ram.sv
hw/rtl/key_to_id_map_table.sv
dv/tb.sv
